// ===== hdl/bse_pkg.sv =====
package bse_pkg;

  localparam int unsigned SIZE_FIELD_W = 4;
  localparam int unsigned SIZE_LOG2_TOP = 10;
  localparam logic [SIZE_FIELD_W-1:0] SIZE_LOG2_RESET = 4'd10;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  typedef struct packed {
    logic opcode;
    logic signed [31:0] key_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] key_out;
    logic last_out;
    logic status;
  } out_item_t;

endpackage

// ===== hdl/bitonic_sort_engine.sv =====
// Bitonic sort engine with one shared compare-exchange unit.
// Input channel (in_valid, in_ready, in_data): each transaction is a load
// or a fetch. A load stores the next key of the current set and gives no
// result. The load that completes a set of 2^size_log2 keys (size_log2
// clamped to 1..log2(MAX_KEYS), at most 10) starts the sort network, which
// handles one key pair at a time in the single two-read, one-write key
// memory: it reads the pair, compares it and writes the first key if it is
// swapped, then writes the second key of a swapped pair in an extra step.
// in_ready stays low while the sort runs.
// A fetch returns one result on the output channel (out_valid, out_ready,
// out_data), set in the output register once that register is free: the
// next sorted key with a last flag on the final key, or an empty status
// when no sorted set is ready. A result waits in the output register while
// out_ready is low; loads are still taken, but the next fetch holds
// in_ready low until that result is taken. Reset clears the counters and
// the sorted flag and sets size_log2 to 10; the key memory is not cleared.
// Writing cfg_data with cfg_we while in_ready is high aborts the current set.
module bitonic_sort_engine #(
  parameter int unsigned MAX_KEYS = 1024,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  bse_pkg::in_item_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output bse_pkg::out_item_t                   out_data,
  input  logic                                 cfg_we,
  input  logic [bse_pkg::SIZE_FIELD_W-1:0]     cfg_data
);

  localparam int unsigned AW = $clog2(MAX_KEYS);
  localparam int unsigned FLOOR_LOG = $clog2(MAX_KEYS + 1) - 1;
  localparam int unsigned LOG_LIMIT =
    (FLOOR_LOG < bse_pkg::SIZE_LOG2_TOP) ? FLOOR_LOG : bse_pkg::SIZE_LOG2_TOP;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SORT = 2'd1;
  localparam logic [1:0] S_OUT = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [bse_pkg::SIZE_FIELD_W-1:0] size_log2_r, size_log2_nxt;
  logic [AW-1:0] load_count_r, load_count_nxt;
  logic [AW-1:0] read_ptr_r, read_ptr_nxt;
  logic sorted_r, sorted_nxt;
  logic err_r, err_nxt;
  logic out_valid_r, out_valid_nxt;
  bse_pkg::out_item_t out_data_r, out_data_nxt;

  logic [bse_pkg::SIZE_FIELD_W-1:0] size_eff;
  logic [AW:0] set_n;
  logic [AW-1:0] n_m1;
  logic in_fire;
  logic out_load;
  logic [AW-1:0] load_idx;
  logic signed [KEY_WIDTH-1:0] key_w;

  logic net_start;
  logic net_busy;
  logic [AW-1:0] net_rd_a;
  logic [AW-1:0] net_rd_b;
  logic net_we;
  logic [AW-1:0] net_waddr;
  logic [KEY_WIDTH-1:0] net_wdata;

  logic ram_we;
  logic [AW-1:0] ram_waddr;
  logic [KEY_WIDTH-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr_a;
  logic [KEY_WIDTH-1:0] ram_rdata_a;
  logic [KEY_WIDTH-1:0] ram_rdata_b;

  always_comb begin
    size_eff = size_log2_r;
    if (size_eff < 4'd1) begin
      size_eff = 4'd1;
    end
    if (size_eff > bse_pkg::SIZE_FIELD_W'(LOG_LIMIT)) begin
      size_eff = bse_pkg::SIZE_FIELD_W'(LOG_LIMIT);
    end
  end

  assign set_n = (AW+1)'(1) << size_eff;
  assign n_m1 = AW'(set_n - 1'b1);
  assign key_w = KEY_WIDTH'(in_data.key_in);

  assign in_ready = (state_r == S_IDLE);
  assign in_fire = in_valid && in_ready;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);
  assign load_idx = sorted_r ? '0 : load_count_r;
  assign net_start = in_fire && (in_data.opcode == bse_pkg::OP_LOAD) && (load_idx == n_m1);

  assign ram_we = net_busy ? net_we : (in_fire && in_data.opcode == bse_pkg::OP_LOAD);
  assign ram_waddr = net_busy ? net_waddr : load_idx;
  assign ram_wdata = net_busy ? net_wdata : key_w;
  assign ram_raddr_a = net_busy ? net_rd_a : read_ptr_r;

  always_comb begin
    state_nxt = state_r;
    size_log2_nxt = size_log2_r;
    load_count_nxt = load_count_r;
    read_ptr_nxt = read_ptr_r;
    sorted_nxt = sorted_r;
    err_nxt = err_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt = out_data_r;
    case (state_r)
      S_IDLE: begin
        if (cfg_we) begin
          size_log2_nxt = cfg_data;
          load_count_nxt = '0;
          read_ptr_nxt = '0;
          sorted_nxt = 1'b0;
        end else if (in_fire) begin
          if (in_data.opcode == bse_pkg::OP_LOAD) begin
            sorted_nxt = 1'b0;
            read_ptr_nxt = '0;
            if (load_idx == n_m1) begin
              load_count_nxt = '0;
              state_nxt = S_SORT;
            end else begin
              load_count_nxt = load_idx + 1'b1;
            end
          end else begin
            err_nxt = !sorted_r;
            state_nxt = S_OUT;
          end
        end
      end
      S_SORT: begin
        if (!net_busy) begin
          sorted_nxt = 1'b1;
          read_ptr_nxt = '0;
          state_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
          if (err_r) begin
            out_data_nxt.key_out = '0;
            out_data_nxt.last_out = 1'b0;
            out_data_nxt.status = bse_pkg::STATUS_EMPTY;
          end else begin
            out_data_nxt.key_out = 32'($signed(ram_rdata_a));
            out_data_nxt.last_out = (read_ptr_r == n_m1);
            out_data_nxt.status = bse_pkg::STATUS_OK;
            if (read_ptr_r == n_m1) begin
              read_ptr_nxt = '0;
              sorted_nxt = 1'b0;
            end else begin
              read_ptr_nxt = read_ptr_r + 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      size_log2_r <= bse_pkg::SIZE_LOG2_RESET;
      load_count_r <= '0;
      read_ptr_r <= '0;
      sorted_r <= 1'b0;
      err_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      size_log2_r <= size_log2_nxt;
      load_count_r <= load_count_nxt;
      read_ptr_r <= read_ptr_nxt;
      sorted_r <= sorted_nxt;
      err_r <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  bse_ram #(
    .WIDTH(KEY_WIDTH),
    .DEPTH(MAX_KEYS)
  ) u_ram (
    .clk(clk),
    .we(ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr_a(ram_raddr_a),
    .rdata_a(ram_rdata_a),
    .raddr_b(net_rd_b),
    .rdata_b(ram_rdata_b)
  );

  bse_net #(
    .MAX_KEYS(MAX_KEYS),
    .KEY_WIDTH(KEY_WIDTH)
  ) u_net (
    .clk(clk),
    .rst_n(rst_n),
    .start(net_start),
    .set_n(set_n),
    .busy(net_busy),
    .rd_addr_a(net_rd_a),
    .rd_addr_b(net_rd_b),
    .rd_data_a(ram_rdata_a),
    .rd_data_b(ram_rdata_b),
    .wr_en(net_we),
    .wr_addr(net_waddr),
    .wr_data(net_wdata)
  );

  a_net_only_in_sort: assert property (@(posedge clk) disable iff (!rst_n)
    net_busy |-> (state_r == S_SORT))
    else $error("sort network active outside the sort phase");

  a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    net_start |-> !net_busy)
    else $error("sort network started while already running");

  a_no_sorted_while_sorting: assert property (@(posedge clk) disable iff (!rst_n)
    net_busy |-> !sorted_r)
    else $error("sorted flag set while the network is running");

  a_last_fetch_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && !err_r && read_ptr_r == n_m1) |=> (!sorted_r && out_data_r.last_out))
    else $error("final key fetched without clearing the sorted set");

endmodule

// ===== hdl/bse_ram.sv =====
module bse_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== hdl/bse_net.sv =====
module bse_net #(
  parameter int unsigned MAX_KEYS = 1024,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [$clog2(MAX_KEYS):0]   set_n,
  output logic                        busy,
  output logic [$clog2(MAX_KEYS)-1:0] rd_addr_a,
  output logic [$clog2(MAX_KEYS)-1:0] rd_addr_b,
  input  logic [KEY_WIDTH-1:0]        rd_data_a,
  input  logic [KEY_WIDTH-1:0]        rd_data_b,
  output logic                        wr_en,
  output logic [$clog2(MAX_KEYS)-1:0] wr_addr,
  output logic [KEY_WIDTH-1:0]        wr_data
);

  localparam int unsigned AW = $clog2(MAX_KEYS);

  localparam logic [1:0] N_IDLE = 2'd0;
  localparam logic [1:0] N_RD = 2'd1;
  localparam logic [1:0] N_CMP = 2'd2;
  localparam logic [1:0] N_WR2 = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [AW:0] k_r, k_nxt;
  logic [AW-1:0] j_r, j_nxt;
  logic [AW-1:0] m_r, m_nxt;
  logic [KEY_WIDTH-1:0] save_r, save_nxt;

  logic [AW-1:0] mask;
  logic [AW-1:0] idx_i;
  logic [AW-1:0] idx_p;
  logic [AW-1:0] half_m1;
  logic up;
  logic swap;
  logic last_m;

  assign mask = j_r - 1'b1;
  assign idx_i = ((m_r & ~mask) << 1) | (m_r & mask);
  assign idx_p = idx_i | j_r;
  assign half_m1 = AW'(set_n >> 1) - 1'b1;
  assign last_m = (m_r == half_m1);
  assign up = (({1'b0, idx_i} & k_r) == '0);
  assign swap = up ? ($signed(rd_data_a) > $signed(rd_data_b))
                   : ($signed(rd_data_b) > $signed(rd_data_a));

  assign busy = (state_r != N_IDLE);
  assign rd_addr_a = idx_i;
  assign rd_addr_b = idx_p;

  always_comb begin
    state_nxt = state_r;
    k_nxt = k_r;
    j_nxt = j_r;
    m_nxt = m_r;
    save_nxt = save_r;
    wr_en = 1'b0;
    wr_addr = idx_i;
    wr_data = rd_data_b;
    case (state_r)
      N_IDLE: begin
        if (start) begin
          k_nxt = (AW+1)'(2);
          j_nxt = AW'(1);
          m_nxt = '0;
          state_nxt = N_RD;
        end
      end
      N_RD: begin
        state_nxt = N_CMP;
      end
      N_CMP: begin
        if (swap) begin
          wr_en = 1'b1;
          save_nxt = rd_data_a;
          state_nxt = N_WR2;
        end else begin
          state_nxt = N_RD;
        end
      end
      N_WR2: begin
        wr_en = 1'b1;
        wr_addr = idx_p;
        wr_data = save_r;
        state_nxt = N_RD;
      end
      default: begin
        state_nxt = N_IDLE;
      end
    endcase

    if ((state_r == N_CMP && !swap) || state_r == N_WR2) begin
      if (!last_m) begin
        m_nxt = m_r + 1'b1;
      end else begin
        m_nxt = '0;
        if (j_r == AW'(1)) begin
          if (k_r == set_n) begin
            state_nxt = N_IDLE;
          end else begin
            k_nxt = k_r << 1;
            j_nxt = k_r[AW-1:0];
          end
        end else begin
          j_nxt = j_r >> 1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
      k_r <= '0;
      j_r <= '0;
      m_r <= '0;
    end else begin
      state_r <= state_nxt;
      k_r <= k_nxt;
      j_r <= j_nxt;
      m_r <= m_nxt;
    end
    save_r <= save_nxt;
  end

endmodule
